// ----- rtl/lru_recency_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// LRU recency table assertion macros
// Shared helpers for the concurrent checks of the recency table.
// ----------------------------------------------------------------------------
`ifndef LRU_RECENCY_TABLE_UNIT_DEFINES_SVH
`define LRU_RECENCY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define LRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define LRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lrt_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU recency table package
// Request codes, fixed field widths and the per-cell control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SLOT_W = 4;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_LOAD  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     used;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/lru_recency_table_unit.sv -----
// ----------------------------------------------------------------------------
// LRU recency table unit
// Fully associative table of slots kept in most-recent-first order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// The table is a row of ENTRIES cells, one per recency position, cell 0 being
// the most recent. Each cell holds a slot number together with that slot's
// key, so keys travel with their slots as the order shifts; the used slots are
// the first used_count positions. In the cycle a request is transferred
// every cell compares its key against the request key and the match vector
// is registered; then, in the move state, the matching position is encoded and
// the row shifts by one place (towards the back for find and insert, towards
// the front for remove) while the result is written into the output register.
// The shift waits for as long as the output register still holds a result
// that has not been transferred, so a stalled result side holds one result
// in the output register and one request in the row before the input stops
// taking requests. The next request cannot be transferred until the shift of
// the previous one is done, set by the compare-then-shift dependence through
// the cell row. A finished result may wait in the output register while the
// next request is transferred and compared. Keys are compared on their low
// KEY_BITS bits (at most 32); slot numbers appear on the four-bit slot port.
// Stored keys need no reset: only used slots are read.

module lru_recency_table_unit #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [lrt_pkg::KIND_W-1:0] kind_i,
  input  wire logic [lrt_pkg::KEY_W-1:0]  key_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            hit_o,
  output logic [lrt_pkg::SLOT_W-1:0]      slot_o,
  output logic                            released_o,
  output logic [lrt_pkg::KEY_W-1:0]       released_key_o
);
  import lrt_pkg::*;

`include "lru_recency_table_unit_defines.svh"

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MOVE = 1'b1;

  logic state_q, state_d;
  logic [CW-1:0] used_count_q, used_count_d;

  logic [KIND_W-1:0]  kind_q;
  logic [KW-1:0]      key_q;
  logic [ENTRIES-1:0] match_q;

  logic               out_valid_q;
  logic               out_hit_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic               out_rel_q;
  logic [KEY_W-1:0]   out_rkey_q;

  logic [KW-1:0]      cmp_key;
  logic               in_xfer;
  logic               move_go;

  logic [IW-1:0]      cell_slot [ENTRIES];
  logic [KW-1:0]      cell_key  [ENTRIES];
  logic [ENTRIES-1:0] cell_match;
  logic [ENTRIES-1:0] tgt_oh;

  logic               hit_w;
  logic               full_w;
  logic [IW-1:0]      pos_bin;
  logic [IW-1:0]      tgt;
  logic [CW-1:0]      cnt_m1;
  logic [IW-1:0]      last_pos;
  logic [IW-1:0]      sel_slot;
  logic [KW-1:0]      sel_key;
  logic               move_front;
  logic               move_back;
  logic [KW-1:0]      moved_key;

  logic               res_hit;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_rel;
  logic [KEY_W-1:0]   res_rkey;
  logic [IW+SLOT_W-1:0] slot_ext;
  logic [KW+KEY_W-1:0]  sel_key_ext;
  logic [KW+KEY_W-1:0]  req_key_ext;

  // A request is taken whenever the row is idle. The shift of a taken
  // request waits until the output register is free or is being emptied.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cmp_key    = key_i[KW-1:0];
  assign move_go    = (state_q == ST_MOVE) && (!out_valid_q || out_ready_i);

  // --------------------------------------------------------------------------
  // Match encoding and target position
  // --------------------------------------------------------------------------
  // Used slots never hold the same key twice, so the match vector is at most
  // one-hot and an OR of the indexes yields the position.
  always_comb begin
    pos_bin = '0;
    for (int p = 0; p < ENTRIES; p++) begin
      pos_bin = pos_bin | (IW'(p) & {IW{match_q[p]}});
    end
  end

  assign hit_w    = |match_q;
  assign full_w   = (used_count_q == CW'(ENTRIES));
  assign cnt_m1   = used_count_q - CW'(1);
  assign last_pos = cnt_m1[IW-1:0];

  // An insert miss lands on the first free position, or on the last one
  // when the table is full; everything else works on the matching position.
  always_comb begin
    tgt = pos_bin;
    if ((kind_q == KIND_INSERT) && !hit_w) begin
      if (full_w) begin
        tgt = IW'(ENTRIES - 1);
      end else begin
        tgt = used_count_q[IW-1:0];
      end
    end
  end

  // Entry at the target position, picked through its one-hot select.
  always_comb begin
    sel_slot = '0;
    sel_key  = '0;
    for (int p = 0; p < ENTRIES; p++) begin
      sel_slot = sel_slot | (cell_slot[p] & {IW{tgt_oh[p]}});
      sel_key  = sel_key  | (cell_key[p]  & {KW{tgt_oh[p]}});
    end
  end

  assign slot_ext    = {{SLOT_W{1'b0}}, sel_slot};
  assign sel_key_ext = {{KEY_W{1'b0}}, sel_key};
  assign req_key_ext = {{KEY_W{1'b0}}, key_q};

  // --------------------------------------------------------------------------
  // Request decode for the shift cycle
  // --------------------------------------------------------------------------
  always_comb begin
    move_front   = 1'b0;
    move_back    = 1'b0;
    moved_key    = sel_key;
    used_count_d = used_count_q;
    res_hit      = 1'b0;
    res_slot     = '0;
    res_rel      = 1'b0;
    res_rkey     = '0;
    if (move_go) begin
      case (kind_q)
        KIND_INSERT: begin
          move_front = 1'b1;
          moved_key  = key_q;
          res_hit    = hit_w;
          res_slot   = slot_ext[SLOT_W-1:0];
          if (!hit_w) begin
            if (full_w) begin
              res_rel  = 1'b1;
              res_rkey = sel_key_ext[KEY_W-1:0];
            end else begin
              used_count_d = used_count_q + CW'(1);
            end
          end
        end
        KIND_FIND: begin
          if (hit_w) begin
            move_front = 1'b1;
            res_hit    = 1'b1;
            res_slot   = slot_ext[SLOT_W-1:0];
          end
        end
        KIND_REMOVE: begin
          if (hit_w) begin
            move_back    = 1'b1;
            res_hit      = 1'b1;
            res_slot     = slot_ext[SLOT_W-1:0];
            res_rel      = 1'b1;
            res_rkey     = req_key_ext[KEY_W-1:0];
            used_count_d = cnt_m1;
          end
        end
        default: begin
          move_front = 1'b0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    localparam logic [IW-1:0] PIDX = IW'(p);

    cell_ctrl_t    ctrl;
    logic [IW-1:0] left_slot;
    logic [KW-1:0] left_key;
    logic [IW-1:0] right_slot;
    logic [KW-1:0] right_key;

    assign tgt_oh[p] = (tgt == PIDX);

    // Moving to the front: position zero takes the moved entry and the
    // positions up to the target take from their left neighbor. Moving to
    // the back: the last used position takes the moved entry and the
    // positions from the target onward take from their right neighbor.
    always_comb begin
      ctrl.used = (CW'(p) < used_count_q);
      ctrl.op   = OP_HOLD;
      if (move_front) begin
        if (p == 0) begin
          ctrl.op = OP_LOAD;
        end else if (PIDX <= tgt) begin
          ctrl.op = OP_LEFT;
        end
      end else if (move_back) begin
        if (PIDX == last_pos) begin
          ctrl.op = OP_LOAD;
        end else if ((PIDX >= tgt) && (PIDX < last_pos)) begin
          ctrl.op = OP_RIGHT;
        end
      end
    end

    if (p == 0) begin : g_first
      assign left_slot = cell_slot[p];
      assign left_key  = cell_key[p];
    end else begin : g_left
      assign left_slot = cell_slot[p-1];
      assign left_key  = cell_key[p-1];
    end

    if (p == ENTRIES - 1) begin : g_last
      assign right_slot = cell_slot[p];
      assign right_key  = cell_key[p];
    end else begin : g_right
      assign right_slot = cell_slot[p+1];
      assign right_key  = cell_key[p+1];
    end

    lrt_cell #(
      .INDEX (p),
      .IW    (IW),
      .KW    (KW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmp_key_i    (cmp_key),
      .left_slot_i  (left_slot),
      .left_key_i   (left_key),
      .right_slot_i (right_slot),
      .right_key_i  (right_key),
      .moved_slot_i (sel_slot),
      .moved_key_i  (moved_key),
      .slot_o       (cell_slot[p]),
      .key_o        (cell_key[p]),
      .match_o      (cell_match[p])
    );
  end

  // --------------------------------------------------------------------------
  // Control and registers
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (move_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_count_q <= used_count_d;
      if (move_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q  <= kind_i;
      key_q   <= cmp_key;
      match_q <= cell_match;
    end
    if (move_go) begin
      out_hit_q  <= res_hit;
      out_slot_q <= res_slot;
      out_rel_q  <= res_rel;
      out_rkey_q <= res_rkey;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign slot_o         = out_slot_q;
  assign released_o     = out_rel_q;
  assign released_key_o = out_rkey_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LRT_ASSERT_IMPL(a_count_range, 1'b1, used_count_q <= CW'(ENTRIES),
                   "used count exceeds the table size")
  `LRT_ASSERT_IMPL(a_unique_match, state_q == ST_MOVE, $onehot0(match_q),
                   "key matched in more than one used slot")
  `LRT_ASSERT_NEXT(a_result_follows, move_go, out_valid_q,
                   "shift cycle did not produce a result")
  `LRT_ASSERT_NEXT(a_remove_count,
                   move_go && (kind_q == KIND_REMOVE) && hit_w,
                   used_count_q == ($past(used_count_q) - CW'(1)),
                   "remove hit did not free a slot")

endmodule

`default_nettype wire

// ----- rtl/lrt_cell.sv -----
// ----------------------------------------------------------------------------
// LRU recency table cell
// One recency position: holds a slot number and that slot's key, compares
// the key, and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrt_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IW    = 4,
  parameter int unsigned KW    = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lrt_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [KW-1:0]      cmp_key_i,
  input  wire logic [IW-1:0]      left_slot_i,
  input  wire logic [KW-1:0]      left_key_i,
  input  wire logic [IW-1:0]      right_slot_i,
  input  wire logic [KW-1:0]      right_key_i,
  input  wire logic [IW-1:0]      moved_slot_i,
  input  wire logic [KW-1:0]      moved_key_i,
  output logic [IW-1:0]           slot_o,
  output logic [KW-1:0]           key_o,
  output logic                    match_o
);
  import lrt_pkg::*;

  logic [IW-1:0] slot_q, slot_d;
  logic [KW-1:0] key_q, key_d;

  always_comb begin
    slot_d = slot_q;
    key_d  = key_q;
    case (ctrl_i.op)
      OP_LEFT: begin
        slot_d = left_slot_i;
        key_d  = left_key_i;
      end
      OP_RIGHT: begin
        slot_d = right_slot_i;
        key_d  = right_key_i;
      end
      OP_LOAD: begin
        slot_d = moved_slot_i;
        key_d  = moved_key_i;
      end
      default: begin
        slot_d = slot_q;
        key_d  = key_q;
      end
    endcase
  end

  // The slot number is part of the order and resets to the identity order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= IW'(INDEX);
    end else begin
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign slot_o  = slot_q;
  assign key_o   = key_q;
  assign match_o = ctrl_i.used && (key_q == cmp_key_i);

endmodule

`default_nettype wire

// ----- test/tb_lru_recency_table_unit.sv -----
// ----------------------------------------------------------------------------
// LRU recency table unit testbench
// Drives insert, find and remove requests through the valid/ready input,
// predicts every result with a behavioral copy of the recency table, and
// checks each result transfer field by field while both sides idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_recency_table_unit;

  import lrt_pkg::*;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned KEY_POOL  = 32;
  localparam int unsigned RAND_REQS = 2000;
  localparam int unsigned CHUNK     = 200;

  // The package names only the three real request kinds; the fourth code is
  // accepted and answered with an all-zero result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              released;
    logic [KEY_W-1:0]  released_key;
  } lookup_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [KIND_W-1:0] kind_i;
  logic [KEY_W-1:0]  key_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              hit_o;
  logic [SLOT_W-1:0] slot_o;
  logic              released_o;
  logic [KEY_W-1:0]  released_key_o;

  // Predicted table: slot number per recency position, key per slot, and
  // the length of the used prefix.
  logic [SLOT_W-1:0] model_order [ENTRIES];
  logic [KEY_W-1:0]  model_keys  [ENTRIES];
  int unsigned       model_used;

  lookup_result_t    pending_results [$];
  logic [KEY_W-1:0]  key_pool [KEY_POOL];

  int unsigned error_count   = 0;
  int unsigned src_gap_max   = 19;
  int unsigned sink_gap_max  = 19;
  int unsigned sink_hold_req = 0;

  lru_recency_table_unit #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .released_o     (released_o),
    .released_key_o (released_key_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Applies one request to the predicted table and returns its result.
  function automatic lookup_result_t lru_apply_request(logic [KIND_W-1:0] kind,
                                                       logic [KEY_W-1:0] key);
    lookup_result_t    res;
    int unsigned       pos;
    int unsigned       p;
    logic [SLOT_W-1:0] moved;
    res = '0;
    pos = ENTRIES;
    // Keys are unique in the used prefix, so the first match is the only one.
    for (p = 0; p < model_used; p++) begin
      if (pos == ENTRIES && model_keys[model_order[p]] == key) pos = p;
    end
    case (kind)
      KIND_INSERT: begin
        if (pos < ENTRIES) begin
          res.hit = 1'b1;
        end else begin
          if (model_used < ENTRIES) begin
            pos = model_used;
            model_used++;
          end else begin
            // Full table: the least recent slot gives up its key.
            pos = ENTRIES - 1;
            res.released     = 1'b1;
            res.released_key = model_keys[model_order[pos]];
          end
          model_keys[model_order[pos]] = key;
        end
      end
      KIND_FIND: begin
        if (pos < ENTRIES) res.hit = 1'b1;
      end
      KIND_REMOVE: begin
        if (pos < ENTRIES) begin
          res.hit          = 1'b1;
          res.released     = 1'b1;
          res.released_key = key;
        end
      end
      default: ;
    endcase
    if (kind != KIND_UNUSED && pos < ENTRIES) begin
      res.slot = model_order[pos];
      moved    = model_order[pos];
      if (kind == KIND_REMOVE) begin
        // The freed slot goes to just past the shrunken used region.
        for (p = pos; p + 1 < model_used; p++) model_order[p] = model_order[p + 1];
        model_order[model_used - 1] = moved;
        model_used--;
      end else begin
        for (p = pos; p > 0; p--) model_order[p] = model_order[p - 1];
        model_order[0] = moved;
      end
    end
    return res;
  endfunction

  // Offers one request after a random gap and records its expected result
  // once the transfer has taken place. Valid is left high so that a request
  // with no gap follows without valid dropping in between.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(lru_apply_request(kind, key));
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly keys from a small pool so that hits, refills and evictions are
  // common; the rest are arbitrary 32-bit keys.
  function automatic logic [KEY_W-1:0] pick_key(int unsigned pool_size);
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_size - 1)];
    return $urandom;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return KIND_INSERT;
    if (roll < 70) return KIND_FIND;
    if (roll < 95) return KIND_REMOVE;
    return KIND_UNUSED;
  endfunction

  // Result side: random ready gaps plus any long hold that a test asks for,
  // then ready stays high until the next result transfer, which is checked
  // against the oldest expectation.
  initial begin
    int unsigned    gap;
    lookup_result_t exp_res;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = $urandom_range(0, sink_gap_max) + sink_hold_req;
      sink_hold_req = 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (hit_o !== exp_res.hit) begin
          $error("hit: expected %0d, actual %0d", exp_res.hit, hit_o);
          error_count++;
        end
        if (slot_o !== exp_res.slot) begin
          $error("slot: expected %0d, actual %0d", exp_res.slot, slot_o);
          error_count++;
        end
        if (released_o !== exp_res.released) begin
          $error("released: expected %0d, actual %0d", exp_res.released, released_o);
          error_count++;
        end
        if (released_key_o !== exp_res.released_key) begin
          $error("released_key: expected %h, actual %h",
                 exp_res.released_key, released_key_o);
          error_count++;
        end
      end
    end
  end

  // Extremes of the key, every kind, hits and misses, reuse of a freed slot,
  // then filling the table until the least recent key is evicted.
  task automatic test_directed();
    int unsigned i;
    send_request(KIND_INSERT, 32'h0000_0000);
    send_request(KIND_INSERT, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 32'h0000_0000);
    send_request(KIND_FIND,   32'hFFFF_FFFF);
    send_request(KIND_FIND,   32'h1234_5678);
    send_request(KIND_REMOVE, 32'h0000_0000);
    send_request(KIND_REMOVE, 32'h0000_0000);
    send_request(KIND_UNUSED, 32'hFFFF_FFFF);
    send_request(KIND_FIND,   32'h0000_0000);
    send_request(KIND_INSERT, 32'h0000_0000);
    // Two keys are in; fifteen more fill the table and then evict once.
    for (i = 0; i < 15; i++) send_request(KIND_INSERT, 32'h1 << (2 * i + 1));
    send_request(KIND_FIND,   32'h0000_0002);
    send_request(KIND_REMOVE, 32'h8000_0000);
    wait_results_drained();
  endtask

  // Random traffic in chunks; each chunk picks a key pool size, which sets
  // how full the table gets, and whether each side idles at all.
  task automatic test_random_traffic();
    int unsigned n;
    int unsigned pool_size;
    for (n = 0; n < RAND_REQS; n++) begin
      if (n % CHUNK == 0) begin
        case ($urandom_range(0, 3))
          0:       pool_size = 4;
          1:       pool_size = 12;
          2:       pool_size = 20;
          default: pool_size = KEY_POOL;
        endcase
        src_gap_max  = $urandom_range(0, 1) ? 19 : 0;
        sink_gap_max = $urandom_range(0, 1) ? 19 : 0;
      end
      send_request(pick_kind(), pick_key(pool_size));
    end
    src_gap_max  = 19;
    sink_gap_max = 19;
  endtask

  // The result side holds off for a long stretch while requests keep coming
  // back to back, so the block fills and stops taking requests.
  task automatic test_output_stall();
    int unsigned n;
    wait_results_drained();
    src_gap_max   = 0;
    sink_hold_req = 200;
    for (n = 0; n < 24; n++) send_request(pick_kind(), pick_key(20));
    src_gap_max = 19;
  endtask

  // The request side pauses until every outstanding result has come back.
  task automatic test_drain_pause();
    int unsigned n;
    for (n = 0; n < 10; n++) send_request(pick_kind(), pick_key(12));
    wait_results_drained();
    for (n = 0; n < 10; n++) send_request(pick_kind(), pick_key(12));
  endtask

  initial begin
    int unsigned i;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    kind_i     = KIND_INSERT;
    key_i      = '0;
    for (i = 0; i < ENTRIES; i++) begin
      model_order[i] = SLOT_W'(i);
      model_keys[i]  = '0;
    end
    model_used = 0;
    for (i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_traffic();
    test_output_stall();
    test_drain_pause();

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_lru_recency_table_unit: PASS");
    end else begin
      $display("tb_lru_recency_table_unit: FAIL");
    end
    $finish;
  end

  // Stops a run that hangs and reports it as a failure.
  initial begin
    #5_000_000;
    $display("tb_lru_recency_table_unit: FAIL");
    $finish;
  end

endmodule
